// ===== hdl/spq_pkg.sv =====
// Shared constants and types for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH = 16;
	localparam int PRI_W = 8;
	localparam int TAG_W = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OCC_W = 5;
	localparam int STS_W = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

	typedef logic [PRI_W-1:0] pri_t;
	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [OCC_W-1:0] occ_t;
	typedef logic [STS_W-1:0] sts_t;

	typedef struct packed {
		pri_t pri;
		tag_t tag;
	} entry_t;

	// Broadcast to every cell in the chain
	typedef struct packed {
		logic   ins_en;
		logic   pop_en;
		entry_t ent;
	} cell_cmd_t;

endpackage

// ===== hdl/spq_if.sv =====
// Request and response channel interfaces for the stable priority queue.
`timescale 1ns / 1ps

interface spq_in_if;
	import spq_pkg::*;

	logic valid;
	logic ready;
	logic opcode;
	pri_t priority_req;
	tag_t tag;

	modport source (output valid, output opcode, output priority_req, output tag,
		input ready);
	modport sink (input valid, input opcode, input priority_req, input tag,
		output ready);
endinterface

interface spq_out_if;
	import spq_pkg::*;

	logic valid;
	logic ready;
	sts_t status;
	pri_t out_priority;
	tag_t out_tag;
	occ_t occupancy;

	modport source (output valid, output status, output out_priority, output out_tag,
		output occupancy, input ready);
	modport sink (input valid, input status, input out_priority, input out_tag,
		input occupancy, output ready);
endinterface

// ===== hdl/spq_cell.sv =====
// One slot of the sorted shift-register queue.
`timescale 1ns / 1ps

module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic               occupied,
	input  logic               left_stay,
	input  spq_pkg::entry_t    left_ent,
	input  spq_pkg::entry_t    right_ent,
	output logic               stay,
	output spq_pkg::entry_t    ent
);
	import spq_pkg::*;

	entry_t ent_q;

	// Entries of equal or higher priority hold their place; the insert lands
	// in the first cell that does not.
	assign stay = occupied && (ent_q.pri >= cmd.ent.pri);
	assign ent  = ent_q;

	always_ff @(posedge clk) begin
		if (cmd.pop_en) begin
			ent_q <= right_ent;
		end else if (cmd.ins_en && !stay) begin
			ent_q <= left_stay ? cmd.ent : left_ent;
		end
	end

endmodule

// ===== hdl/stable_priority_queue.sv =====
// Top level of the stable priority queue: cell chain, fill count and result register.
`timescale 1ns / 1ps

// Sorted queue of DEPTH entries kept in a chain of cells, head in cell 0.
// On each request (insert or pop), all cells compare their
// priority with the new one in parallel and shift toward the tail (insert)
// or the head (pop) in the same clock, so one request is accepted per cycle
// while the response register is free or being drained. Inserts go behind
// every entry of equal or higher priority, giving FIFO order within a level.
// An insert on a full queue returns status 2 and leaves the queue alone; a
// pop on an empty queue returns status 1. Occupancy reports the count after
// the request. Entries carry no reset; only occupied slots are ever read.
module stable_priority_queue (
	input  logic              clk,
	input  logic              arst_n,
	spq_in_if.sink            req,
	spq_out_if.source         rsp
);
	import spq_pkg::*;

	cnt_t      count_q;
	cnt_t      count_nxt;
	logic      accept;
	logic      full;
	logic      empty;
	cell_cmd_t cmd;
	sts_t      sts;

	logic   rsp_valid_q;
	sts_t   sts_q;
	pri_t   pri_q;
	tag_t   tag_q;
	occ_t   occ_q;

	logic   stay [DEPTH];
	entry_t ent  [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	assign cmd.ins_en = accept && (req.opcode == OP_INSERT) && !full;
	assign cmd.pop_en = accept && (req.opcode == OP_POP) && !empty;
	assign cmd.ent    = '{pri: req.priority_req, tag: req.tag};

	always_comb begin
		count_nxt = count_q;
		sts       = STS_OK;
		if (req.opcode == OP_INSERT) begin
			if (full) begin
				sts = STS_FULL;
			end else begin
				count_nxt = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				sts = STS_EMPTY;
			end else begin
				count_nxt = count_q - 1'b1;
			end
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic   occ_i;
			logic   lstay_i;
			entry_t left_i;
			entry_t right_i;

			assign occ_i = (CNT_W'(i) < count_q);
			if (i == 0) begin : g_head
				assign lstay_i = 1'b1;
				assign left_i  = cmd.ent;
			end else begin : g_body
				assign lstay_i = stay[i-1];
				assign left_i  = ent[i-1];
			end
			if (i == DEPTH - 1) begin : g_tail
				assign right_i = ent[i];
			end else begin : g_inner
				assign right_i = ent[i+1];
			end

			spq_cell u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.occupied  (occ_i),
				.left_stay (lstay_i),
				.left_ent  (left_i),
				.right_ent (right_i),
				.stay      (stay[i]),
				.ent       (ent[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sts_q <= sts;
			occ_q <= OCC_W'(count_nxt);
			if (cmd.pop_en) begin
				pri_q <= ent[0].pri;
				tag_q <= ent[0].tag;
			end else begin
				pri_q <= '0;
				tag_q <= '0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = sts_q;
	assign rsp.out_priority = pri_q;
	assign rsp.out_tag      = tag_q;
	assign rsp.occupancy    = occ_q;

endmodule
